@@ design/bpk_pkg.sv @@
package bpk_pkg;

   // Number of result beats that one input beat produces.
   typedef struct packed {
      logic has_first;
      logic has_second;
   } bpk_ctl_type;

   // Width of the result queue's occupancy count (holds 0..2).
   localparam int unsigned QCNT_W = 2;

endpackage

@@ design/bpk_merge.sv @@
module bpk_merge #(
   parameter int unsigned LANES = 4
) (
   input  logic [8*LANES-1:0]         held_data,
   input  logic [$clog2(LANES)-1:0]   held_cnt,
   input  logic [8*LANES-1:0]         beat_data,
   input  logic [LANES-1:0]           beat_keep,
   input  logic                       beat_last,
   output logic [8*LANES-1:0]         first_data,
   output logic [LANES-1:0]           first_keep,
   output logic                       first_last,
   output logic [8*LANES-1:0]         second_data,
   output logic [LANES-1:0]           second_keep,
   output bpk_pkg::bpk_ctl_type       ctl,
   output logic [8*LANES-1:0]         next_held_data,
   output logic [$clog2(LANES)-1:0]   next_held_cnt
);
   import bpk_pkg::*;

   localparam int unsigned CW = $clog2(LANES);
   localparam int unsigned TW = $clog2(2*LANES);

   logic [7:0]    pack_bytes [2*LANES];
   logic [TW-1:0] lane_pos [LANES];
   logic [TW-1:0] total_cnt;
   logic [TW-1:0] rem_cnt;
   logic          full;

   // Target position of each input lane: held bytes plus kept lanes below it.
   always_comb begin
      logic [LANES-1:0] low_mask;
      for (int i = 0; i < LANES; i++) begin
         for (int b = 0; b < LANES; b++) begin
            low_mask[b] = (b < i);
         end
         lane_pos[i] = TW'(held_cnt) + TW'($countones(beat_keep & low_mask));
      end
   end

   // Held bytes first, then the kept lanes compacted behind them.
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         pack_bytes[j] = (TW'(j) < TW'(held_cnt)) ? held_data[8*j +: 8] : 8'h00;
      end
      for (int j = LANES; j < 2*LANES; j++) begin
         pack_bytes[j] = 8'h00;
      end
      for (int i = 0; i < LANES; i++) begin
         for (int j = 0; j < 2*LANES; j++) begin
            if (beat_keep[i] && (lane_pos[i] == TW'(j))) begin
               pack_bytes[j] = beat_data[8*i +: 8];
            end
         end
      end
   end

   // Byte counts for this beat.
   assign total_cnt = TW'(held_cnt) + TW'($countones(beat_keep));
   assign full      = (total_cnt >= TW'(LANES));
   assign rem_cnt   = full ? (total_cnt - TW'(LANES)) : total_cnt;

   // Result words and keep masks.
   always_comb begin
      for (int j = 0; j < LANES; j++) begin
         first_data[8*j +: 8]  = pack_bytes[j];
         second_data[8*j +: 8] = pack_bytes[LANES + j];
         first_keep[j]         = (TW'(j) < total_cnt);
         second_keep[j]        = (TW'(j) < rem_cnt);
      end
   end

   // A full word ends the packet only when nothing is left over.
   assign first_last     = beat_last && (!full || (total_cnt == TW'(LANES)));
   assign ctl.has_first  = full || beat_last;
   assign ctl.has_second = full && beat_last && (rem_cnt != '0);

   // The leftover bytes stay held unless the packet ends here.
   assign next_held_data = full ? second_data : first_data;
   assign next_held_cnt  = beat_last ? '0 : CW'(rem_cnt);

endmodule

@@ design/bpk_rsp_queue.sv @@
module bpk_rsp_queue #(
   parameter int unsigned WIDTH = 38
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push_a,
   input  logic [WIDTH-1:0]           data_a,
   input  logic                       push_b,
   input  logic [WIDTH-1:0]           data_b,
   input  logic                       pop,
   output logic                       head_valid,
   output logic [WIDTH-1:0]           head_data,
   output logic [bpk_pkg::QCNT_W-1:0] space
);
   import bpk_pkg::*;

   logic [WIDTH-1:0]  q0_ff, q0_in;
   logic [WIDTH-1:0]  q1_ff, q1_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic [QCNT_W-1:0] cnt_left;

   // Occupancy after this cycle's pop, and room left for new beats.
   assign cnt_left = cnt_ff - QCNT_W'(pop);
   assign space    = QCNT_W'(2) - cnt_left;

   // Shift the head out on pop, then append pushed beats in order.
   always_comb begin
      q0_in  = q0_ff;
      q1_in  = q1_ff;
      cnt_in = cnt_left;
      if (pop) begin
         q0_in = q1_ff;
      end
      if (push_a) begin
         if (cnt_in == '0) begin
            q0_in = data_a;
         end else begin
            q1_in = data_a;
         end
         cnt_in = cnt_in + 1'b1;
      end
      if (push_b) begin
         if (cnt_in == '0) begin
            q0_in = data_b;
         end else begin
            q1_in = data_b;
         end
         cnt_in = cnt_in + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      q0_ff <= q0_in;
      q1_ff <= q1_in;
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
   end

   assign head_valid = (cnt_ff != '0);
   assign head_data  = q0_ff;

endmodule

@@ design/stream_null_byte_packer.sv @@
// An accepted beat passes the input register, then the result queue, before its first result beat shows.
// Throughput: one input beat per cycle while the result queue has room; a beat that yields two
// result beats fills both entries of the two-entry result queue.
// The input register and the two-entry result queue bound how far stalls back up.
// Reset (synchronous, active high) empties both stages and clears the held bytes.
module stream_null_byte_packer #(
   parameter int unsigned BYTE_LANES = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic [8*BYTE_LANES-1:0] req_data,
   input  logic [BYTE_LANES-1:0]   req_keep,
   input  logic                    req_last,
   output logic                    rsp_valid,
   input  logic                    rsp_stall,
   output logic [8*BYTE_LANES-1:0] rsp_data,
   output logic [BYTE_LANES-1:0]   rsp_keep,
   output logic                    rsp_last,
   output logic                    rsp_step_end
);
   import bpk_pkg::*;

   localparam int unsigned DW = 8*BYTE_LANES;
   localparam int unsigned CW = $clog2(BYTE_LANES);
   localparam int unsigned QW = DW + BYTE_LANES + 2;

   logic              s1_valid_ff, s1_valid_in;
   logic [DW-1:0]     s1_data_ff, s1_data_in;
   logic [BYTE_LANES-1:0] s1_keep_ff, s1_keep_in;
   logic              s1_last_ff, s1_last_in;
   logic [DW-1:0]     held_data_ff, held_data_in;
   logic [CW-1:0]     held_cnt_ff, held_cnt_in;

   logic [DW-1:0]         first_data, second_data;
   logic [BYTE_LANES-1:0] first_keep, second_keep;
   logic                  first_last;
   bpk_ctl_type           ctl;
   logic [DW-1:0]         next_held_data;
   logic [CW-1:0]         next_held_cnt;

   logic [QCNT_W-1:0] q_space;
   logic [QCNT_W-1:0] need;
   logic              advance;
   logic              accept;
   logic              pop;
   logic [QW-1:0]     entry_a, entry_b, head_data;

   // Byte compaction and merge with the held remainder.
   bpk_merge #(.LANES(BYTE_LANES)) u_merge (
      .held_data      (held_data_ff),
      .held_cnt       (held_cnt_ff),
      .beat_data      (s1_data_ff),
      .beat_keep      (s1_keep_ff),
      .beat_last      (s1_last_ff),
      .first_data     (first_data),
      .first_keep     (first_keep),
      .first_last     (first_last),
      .second_data    (second_data),
      .second_keep    (second_keep),
      .ctl            (ctl),
      .next_held_data (next_held_data),
      .next_held_cnt  (next_held_cnt)
   );

   // The registered beat moves on once the queue has room for all its results.
   assign need      = QCNT_W'(ctl.has_first) + QCNT_W'(ctl.has_second);
   assign advance   = s1_valid_ff && (need <= q_space);
   assign req_stall = s1_valid_ff && !advance;
   assign accept    = req_valid && !req_stall;

   // Input register and held-byte state.
   always_comb begin
      s1_valid_in  = s1_valid_ff;
      s1_data_in   = s1_data_ff;
      s1_keep_in   = s1_keep_ff;
      s1_last_in   = s1_last_ff;
      held_data_in = held_data_ff;
      held_cnt_in  = held_cnt_ff;
      if (advance) begin
         s1_valid_in  = 1'b0;
         held_data_in = next_held_data;
         held_cnt_in  = next_held_cnt;
      end
      if (accept) begin
         s1_valid_in = 1'b1;
         s1_data_in  = req_data;
         s1_keep_in  = req_keep;
         s1_last_in  = req_last;
      end
   end

   always_ff @(posedge clock) begin
      s1_data_ff   <= s1_data_in;
      s1_keep_ff   <= s1_keep_in;
      s1_last_ff   <= s1_last_in;
      held_data_ff <= held_data_in;
      if (reset) begin
         s1_valid_ff <= 1'b0;
         held_cnt_ff <= '0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         held_cnt_ff <= held_cnt_in;
      end
   end

   // Result beats: the last one produced by an input beat carries step_end.
   assign entry_a = {first_data, first_keep, first_last, !ctl.has_second};
   assign entry_b = {second_data, second_keep, 1'b1, 1'b1};
   assign pop     = rsp_valid && !rsp_stall;

   bpk_rsp_queue #(.WIDTH(QW)) u_rsp_queue (
      .clock      (clock),
      .reset      (reset),
      .push_a     (advance && ctl.has_first),
      .data_a     (entry_a),
      .push_b     (advance && ctl.has_second),
      .data_b     (entry_b),
      .pop        (pop),
      .head_valid (rsp_valid),
      .head_data  (head_data),
      .space      (q_space)
   );

   assign {rsp_data, rsp_keep, rsp_last, rsp_step_end} = head_data;

endmodule

@@ design/bpk_checker.sv @@
module bpk_checker #(
   parameter int unsigned BYTE_LANES = 4
) (
   input logic                    clock,
   input logic                    reset,
   input logic                    rsp_valid,
   input logic                    rsp_stall,
   input logic [8*BYTE_LANES-1:0] rsp_data,
   input logic [BYTE_LANES-1:0]   rsp_keep,
   input logic                    rsp_last,
   input logic                    rsp_step_end
);

   logic [8*BYTE_LANES-1:0] keep_bytes;

   // Byte-wide expansion of the keep mask.
   always_comb begin
      for (int j = 0; j < BYTE_LANES; j++) begin
         keep_bytes[8*j +: 8] = {8{rsp_keep[j]}};
      end
   end

   // Kept lanes always form a contiguous run from lane zero.
   a_keep_contig: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_keep & (rsp_keep + 1'b1)) == '0))
      else $error("result keep mask is not contiguous");

   // Every beat before the end of a packet is a full word.
   a_full_word: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_last) |-> (rsp_keep == '1))
      else $error("short result beat without last");

   // A packet end is always the final result of its input beat.
   a_last_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_step_end)
      else $error("last beat without step_end");

   // Lanes that are not kept carry zero.
   a_zero_lanes: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_data & ~keep_bytes) == '0))
      else $error("unkept result lane is not zero");

   // A stalled result beat holds.
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)
                                    && $stable(rsp_keep) && $stable(rsp_last)))
      else $error("stalled result beat changed");

endmodule

bind stream_null_byte_packer bpk_checker #(.BYTE_LANES(BYTE_LANES)) u_bpk_checker (
   .clock        (clock),
   .reset        (reset),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_data     (rsp_data),
   .rsp_keep     (rsp_keep),
   .rsp_last     (rsp_last),
   .rsp_step_end (rsp_step_end)
);

@@ bench/stream_null_byte_packer_tb.sv @@
`timescale 1ns / 100ps

// One result beat as the packer should send it.
typedef struct packed {
   logic [31:0] data;
   logic [3:0]  keep;
   logic        last;
   logic        step_end;
} packed_word_type;

// Tracks the bytes the packer should be holding and the beats it owes.
class packer_scoreboard;
   logic [23:0]     held_bytes;
   int unsigned     held_count;
   packed_word_type pending_words[$];
   int unsigned     mismatches;
   int unsigned     beats_in;
   int unsigned     words_checked;
   int unsigned     packets;
   int unsigned     overfills;
   int unsigned     empty_lasts;
   int unsigned     dropped;

   function new();
      held_bytes    = '0;
      held_count    = 0;
      mismatches    = 0;
      beats_in      = 0;
      words_checked = 0;
      packets       = 0;
      overfills     = 0;
      empty_lasts   = 0;
      dropped       = 0;
   endfunction

   // Appends the kept bytes of an accepted input beat to the held bytes and
   // queues every full or closing word that this beat produces.
   function void note_beat(logic [31:0] data, logic [3:0] keep, logic last);
      logic [7:0]      lanes [0:7];
      packed_word_type outs [0:1];
      int unsigned     n;
      int unsigned     made;
      n    = held_count;
      made = 0;
      beats_in++;
      if (last)
         packets++;
      if (keep == 4'h0 && !last)
         dropped++;
      for (int i = 0; i < 8; i++)
         lanes[i] = 8'h00;
      for (int i = 0; i < 3; i++)
         if (i < n)
            lanes[i] = held_bytes[8*i +: 8];
      for (int i = 0; i < 4; i++) begin
         if (keep[i]) begin
            lanes[n] = data[8*i +: 8];
            n++;
         end
      end
      outs[0] = '0;
      outs[1] = '0;

      // A full word goes out first; it closes the packet only if nothing is left.
      if (n >= 4) begin
         outs[0].data = {lanes[3], lanes[2], lanes[1], lanes[0]};
         outs[0].keep = 4'hF;
         outs[0].last = last && (n == 4);
         made = 1;
         n = n - 4;
         for (int i = 0; i < 4; i++)
            lanes[i] = lanes[i + 4];
         if (last && n > 0)
            overfills++;
      end

      // On last, flush the remainder, or send an empty word if nothing went out.
      if (last && (n > 0 || made == 0)) begin
         for (int i = 0; i < 4; i++)
            if (i < n)
               outs[made].data[8*i +: 8] = lanes[i];
         outs[made].keep = 4'((1 << n) - 1);
         outs[made].last = 1'b1;
         if (n == 0)
            empty_lasts++;
         made++;
         n = 0;
      end

      if (made > 0)
         outs[made - 1].step_end = 1'b1;
      for (int i = 0; i < made; i++)
         pending_words.push_back(outs[i]);

      held_bytes = '0;
      for (int i = 0; i < 3; i++)
         if (i < n)
            held_bytes[8*i +: 8] = lanes[i];
      held_count = n;
   endfunction

   // Compares an accepted result beat with the oldest word still owed.
   task check_word(logic [31:0] data, logic [3:0] keep, logic last, logic step_end);
      packed_word_type want;
      if (pending_words.size() == 0) begin
         report($sformatf("result beat with nothing owed: data=%h keep=%h last=%b",
                          data, keep, last));
         return;
      end
      want = pending_words.pop_front();
      words_checked++;
      if (data !== want.data)
         report($sformatf("data %h, wanted %h", data, want.data));
      if (keep !== want.keep)
         report($sformatf("keep %h, wanted %h", keep, want.keep));
      if (last !== want.last)
         report($sformatf("last %b, wanted %b", last, want.last));
      if (step_end !== want.step_end)
         report($sformatf("step_end %b, wanted %b", step_end, want.step_end));
   endtask

   task report(string msg);
      mismatches++;
      $display("%0t mismatch %0d: %s", $time, mismatches, msg);
   endtask
endclass

module stream_null_byte_packer_tb;
   localparam int unsigned LANES          = 4;
   localparam int unsigned CYCLE_LIMIT    = 400000;
   localparam int unsigned SQUEEZE_CYCLES = 300;
   localparam int unsigned DRAIN_CYCLES   = 20;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_stall;
   logic [31:0] req_data;
   logic [3:0]  req_keep;
   logic        req_last;
   logic        rsp_valid;
   logic        rsp_stall;
   logic [31:0] rsp_data;
   logic [3:0]  rsp_keep;
   logic        rsp_last;
   logic        rsp_step_end;

   packer_scoreboard board;
   bit          sender_gaps  = 1'b1;
   bit          sink_gaps    = 1'b1;
   bit          squeeze_req  = 1'b0;
   int unsigned longest_hold = 0;
   int unsigned cycle_count  = 0;

   stream_null_byte_packer #(.BYTE_LANES(LANES)) DUT (
      .clock        (clock),
      .reset        (reset),
      .req_valid    (req_valid),
      .req_stall    (req_stall),
      .req_data     (req_data),
      .req_keep     (req_keep),
      .req_last     (req_last),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_data     (rsp_data),
      .rsp_keep     (rsp_keep),
      .rsp_last     (rsp_last),
      .rsp_step_end (rsp_step_end)
   );

   always #5 clock = ~clock;

   // Idle lengths: mostly none or short, now and then long.
   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 55)
         return 0;
      if (r < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   // Full words are common, null beats and sparse masks less so.
   function automatic logic [3:0] pick_keep();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 40)
         return 4'hF;
      if (r < 50)
         return 4'h0;
      return 4'($urandom_range(0, 15));
   endfunction

   function automatic int unsigned pick_packet_len();
      int unsigned r;
      r = $urandom_range(0, 99);
      if (r < 70)
         return $urandom_range(1, 4);
      if (r < 95)
         return $urandom_range(5, 10);
      return $urandom_range(11, 30);
   endfunction

   // Output side: random stall bursts, plus one long hold when asked for.
   initial begin : sink
      int unsigned left;
      int unsigned run;
      rsp_stall = 1'b0;
      left = 0;
      run  = 0;
      forever begin
         @(negedge clock);
         if (squeeze_req) begin
            squeeze_req = 1'b0;
            left = SQUEEZE_CYCLES;
         end else if (left == 0 && sink_gaps && $urandom_range(0, 99) < 30) begin
            left = pick_gap();
         end
         if (left > 0) begin
            rsp_stall <= 1'b1;
            left--;
            run++;
            if (run > longest_hold)
               longest_hold = run;
         end else begin
            rsp_stall <= 1'b0;
            run = 0;
         end
      end
   end

   // Every accepted result beat is checked against the prediction.
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.check_word(rsp_data, rsp_keep, rsp_last, rsp_step_end);
   end

   // Give up if the run hangs.
   initial begin : watchdog
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("Timed out after %0d cycles.", cycle_count);
      $display("== FAIL ==");
      $finish;
   end

   // Offers one input beat after an optional idle gap and waits for acceptance.
   task automatic send_beat(input logic [31:0] data, input logic [3:0] keep,
                            input logic last);
      int unsigned gap;
      gap = sender_gaps ? pick_gap() : 0;
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         req_data  <= $urandom;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= data;
      req_keep  <= keep;
      req_last  <= last;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.note_beat(data, keep, last);
   endtask

   task automatic send_packet(input int unsigned words);
      for (int unsigned w = 0; w < words; w++)
         send_beat($urandom, pick_keep(), w == words - 1);
   endtask

   task automatic send_until(input int unsigned target);
      while (board.beats_in < target)
         send_packet(pick_packet_len());
   endtask

   initial begin
      board     = new();
      reset     = 1'b1;
      req_valid = 1'b0;
      req_data  = '0;
      req_keep  = '0;
      req_last  = 1'b0;
      repeat (12) @(negedge clock);
      reset <= 1'b0;

      // Directed beats: null beats, empty last, exact fill, overfill, flushes.
      send_beat(32'hDEADBEEF, 4'h0, 1'b0);
      send_beat(32'h12345678, 4'h0, 1'b1);
      send_beat(32'hFFFFFFFF, 4'hF, 1'b0);
      send_beat(32'h00000000, 4'hF, 1'b1);
      send_beat(32'hA5A5A511, 4'h1, 1'b0);
      send_beat(32'h44332211, 4'h7, 1'b1);
      send_beat(32'hFF030201, 4'h7, 1'b0);
      send_beat(32'h07060504, 4'hF, 1'b1);
      send_beat(32'h0000AA00, 4'h2, 1'b0);
      send_beat(32'hCC00BB00, 4'hA, 1'b0);
      send_beat(32'hFFFFFFFF, 4'h0, 1'b1);
      send_beat(32'h00330011, 4'h5, 1'b0);
      send_beat(32'h88770000, 4'hC, 1'b0);
      send_beat(32'h99000000, 4'h8, 1'b1);
      send_beat(32'h3C2B1A00, 4'hE, 1'b0);
      send_beat(32'h6F5E4D00, 4'hE, 1'b0);
      send_beat(32'hFFFF0F0E, 4'h3, 1'b1);
      send_beat(32'h80808080, 4'hF, 1'b0);
      send_beat(32'h7F7F7F7F, 4'hF, 1'b0);
      send_beat(32'hFFFFFF55, 4'h1, 1'b1);
      send_beat(32'h00BEEF00, 4'h6, 1'b0);
      send_beat(32'h00000000, 4'h0, 1'b0);
      send_beat(32'hCA0000FE, 4'h9, 1'b1);

      // Random packets with idling on both sides.
      send_until(400);

      // Back-to-back stretch with no idling.
      sender_gaps = 1'b0;
      sink_gaps   = 1'b0;
      send_until(650);

      // Long output hold while input keeps coming, so the block backs up.
      squeeze_req = 1'b1;
      send_until(700);

      sender_gaps = 1'b1;
      sink_gaps   = 1'b1;
      send_until(1100);

      @(negedge clock);
      req_valid <= 1'b0;
      sink_gaps = 1'b0;
      while (board.pending_words.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Run covered %0d input beats in %0d packets; %0d result beats checked.",
               board.beats_in, board.packets, board.words_checked);
      $display("Overfilled last beats %0d, empty last words %0d, null beats %0d, %s %0d.",
               board.overfills, board.empty_lasts, board.dropped,
               "longest output hold in cycles", longest_hold);
      if (board.mismatches == 0)
         $display("== PASS ==");
      else
         $display("== FAIL ==");
      $finish;
   end
endmodule

@@ files.f @@
design/bpk_pkg.sv
design/bpk_merge.sv
design/bpk_rsp_queue.sv
design/stream_null_byte_packer.sv
design/bpk_checker.sv
bench/stream_null_byte_packer_tb.sv
